[rtl/tsis_pkg.sv]
package tsis_pkg;

    localparam int DEPTH_PER_STACK = 32;
    localparam int STACK_COUNT     = 3;
    localparam int DATA_W          = 32;
    localparam int CNT_W           = $clog2(DEPTH_PER_STACK + 1);

    typedef enum logic [1:0] {
        OP_PUSH  = 2'd0,
        OP_POP   = 2'd1,
        OP_PEEK  = 2'd2,
        OP_QUERY = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } status_t;

    // shift command that a stack hands down its row of cells
    typedef struct packed {
        logic push;
        logic pop;
    } stk_cmd_t;

endpackage

[rtl/three_stacks_interleaved_store.sv]
// Three LIFO stacks of 32 elements of 32 bits each, one operation per item
// (push, pop, peek top, query empty). busy stays low, so an item may be
// given in every cycle; its result appears on the cycle after start with
// done high for that one cycle, and must be taken then, as it is not held.
// Each stack is a row of cells that shifts one place per push or pop. A
// push on a full stack reports overflow, a pop or peek on an empty stack
// reports underflow, and neither changes the stacks. Stack select 3 acts
// as a stack that is always empty and never holds anything.
module three_stacks_interleaved_store
    import tsis_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [1:0]               op,
    input  logic [1:0]               stack_sel,
    input  logic signed [DATA_W-1:0] push_value,
    output logic                     done,
    output logic signed [DATA_W-1:0] read_value,
    output logic [1:0]               status,
    output logic                     stack_empty
);

    logic              accept;
    stk_cmd_t          cmd [STACK_COUNT];
    logic [DATA_W-1:0] top  [STACK_COUNT];
    logic [CNT_W-1:0]  cnt  [STACK_COUNT];

    logic              sel_valid;
    logic [DATA_W-1:0] sel_top;
    logic [CNT_W-1:0]  sel_cnt;
    logic              is_full;
    logic              is_empty;
    logic              do_push;
    logic              do_pop;

    logic              done_reg;
    logic              done_next;
    logic [DATA_W-1:0] read_value_reg;
    logic [DATA_W-1:0] read_value_next;
    status_t           status_reg;
    status_t           status_next;
    logic              empty_reg;
    logic              empty_next;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // selected stack view
    always_comb
    begin
        sel_valid = 1'b1;
        sel_top   = top[0];
        sel_cnt   = cnt[0];
        case (stack_sel)
            2'd0:
            begin
                sel_top = top[0];
                sel_cnt = cnt[0];
            end
            2'd1:
            begin
                sel_top = top[1];
                sel_cnt = cnt[1];
            end
            2'd2:
            begin
                sel_top = top[2];
                sel_cnt = cnt[2];
            end
            default:
            begin
                sel_valid = 1'b0;
                sel_top   = '0;
                sel_cnt   = '0;
            end
        endcase
    end

    assign is_full  = (sel_cnt == CNT_W'(DEPTH_PER_STACK));
    assign is_empty = (sel_cnt == '0);

    // operation decode and result
    always_comb
    begin
        do_push         = 1'b0;
        do_pop          = 1'b0;
        read_value_next = '0;
        status_next     = ST_OK;
        empty_next      = 1'b1;
        case (op_t'(op))
            OP_PUSH:
            begin
                if (!sel_valid || is_full)
                begin
                    status_next = ST_OVERFLOW;
                    empty_next  = !sel_valid || is_empty;
                end
                else
                begin
                    do_push    = 1'b1;
                    empty_next = 1'b0;
                end
            end
            OP_POP, OP_PEEK:
            begin
                if (!sel_valid || is_empty)
                begin
                    status_next = ST_UNDERFLOW;
                end
                else
                begin
                    read_value_next = sel_top;
                    do_pop          = (op_t'(op) == OP_POP);
                    empty_next      = do_pop && (sel_cnt == CNT_W'(1));
                end
            end
            default:
            begin
                empty_next = !sel_valid || is_empty;
            end
        endcase
        done_next = accept;
    end

    // one stack for each of the select values 0 to 2
    for (genvar s = 0; s < STACK_COUNT; s++)
    begin : g_stack
        assign cmd[s].push = accept && do_push && (stack_sel == 2'(s));
        assign cmd[s].pop  = accept && do_pop  && (stack_sel == 2'(s));

        tsis_stack u_stack
        (
            .clk        (clk),
            .rst_n      (rst_n),
            .cmd        (cmd[s]),
            .push_value (push_value),
            .top_value  (top[s]),
            .fill_count (cnt[s])
        );
    end

    // result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            read_value_reg <= read_value_next;
            status_reg     <= status_next;
            empty_reg      <= empty_next;
        end
    end

    assign done        = done_reg;
    assign read_value  = read_value_reg;
    assign status      = status_reg;
    assign stack_empty = empty_reg;

endmodule

[rtl/tsis_cell.sv]
module tsis_cell
    import tsis_pkg::*;
(
    input  logic              clk,
    input  stk_cmd_t          cmd,
    input  logic [DATA_W-1:0] upper_value,
    input  logic [DATA_W-1:0] lower_value,
    output logic [DATA_W-1:0] data
);

    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;

    // push takes the newer neighbor, pop takes the older one
    always_comb
    begin
        data_next = data_reg;
        if (cmd.push)
        begin
            data_next = upper_value;
        end
        else if (cmd.pop)
        begin
            data_next = lower_value;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

[rtl/tsis_stack.sv]
module tsis_stack
    import tsis_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  stk_cmd_t          cmd,
    input  logic [DATA_W-1:0] push_value,
    output logic [DATA_W-1:0] top_value,
    output logic [CNT_W-1:0]  fill_count
);

    logic [DATA_W-1:0] cell_data [DEPTH_PER_STACK];
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;

    // row of cells, cell 0 holds the top of the stack
    for (genvar i = 0; i < DEPTH_PER_STACK; i++)
    begin : g_cell
        logic [DATA_W-1:0] upper;
        logic [DATA_W-1:0] lower;

        if (i == 0)
        begin : g_first
            assign upper = push_value;
        end
        else
        begin : g_mid_up
            assign upper = cell_data[i-1];
        end

        if (i == DEPTH_PER_STACK - 1)
        begin : g_last
            assign lower = cell_data[i];
        end
        else
        begin : g_mid_low
            assign lower = cell_data[i+1];
        end

        tsis_cell u_cell
        (
            .clk         (clk),
            .cmd         (cmd),
            .upper_value (upper),
            .lower_value (lower),
            .data        (cell_data[i])
        );
    end

    // fill count, commands arrive already checked against full and empty
    always_comb
    begin
        count_next = count_reg;
        if (cmd.push)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (cmd.pop)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    assign top_value  = cell_data[0];
    assign fill_count = count_reg;

endmodule

[sim/tb_three_stacks_interleaved_store.sv]
`timescale 1ns / 100ps

module tb_three_stacks_interleaved_store;
    import tsis_pkg::*;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        status_t                  code;
        logic                     empty;
    } stack_result_t;

    logic                     clk;
    logic                     rst_n;
    logic                     start;
    logic                     busy;
    logic [1:0]               op;
    logic [1:0]               stack_sel;
    logic signed [DATA_W-1:0] push_value;
    logic                     done;
    logic signed [DATA_W-1:0] read_value;
    logic [1:0]               status;
    logic                     stack_empty;

    // shadow copy of the three stacks
    logic signed [DATA_W-1:0] shadow_store [STACK_COUNT*DEPTH_PER_STACK];
    int                       shadow_fill [STACK_COUNT];

    stack_result_t pending_results [$];
    int            idle_pct;
    int            err_cnt;
    int            items_sent;
    int            n_ok;
    int            n_overflow;
    int            n_underflow;

    three_stacks_interleaved_store i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .op          (op),
        .stack_sel   (stack_sel),
        .push_value  (push_value),
        .done        (done),
        .read_value  (read_value),
        .status      (status),
        .stack_empty (stack_empty)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // run limit
    initial
    begin
        #(2_000_000);
        $display("Regression FAIL");
        $finish;
    end

    // apply one operation to the shadow stacks and return its result
    function automatic stack_result_t apply_stack_op(op_t kind, logic [1:0] sel,
                                                     logic signed [DATA_W-1:0] value);
        stack_result_t r;
        int            cnt;
        r.value = '0;
        r.code  = ST_OK;
        r.empty = 1'b1;
        if (sel >= STACK_COUNT)
        begin
            // unused select: never holds anything
            if (kind == OP_PUSH)
                r.code = ST_OVERFLOW;
            else if (kind == OP_POP || kind == OP_PEEK)
                r.code = ST_UNDERFLOW;
        end
        else
        begin
            cnt = shadow_fill[sel];
            case (kind)
                OP_PUSH:
                begin
                    if (cnt >= DEPTH_PER_STACK)
                        r.code = ST_OVERFLOW;
                    else
                    begin
                        shadow_store[sel + STACK_COUNT*cnt] = value;
                        cnt++;
                    end
                end
                OP_POP, OP_PEEK:
                begin
                    if (cnt == 0)
                        r.code = ST_UNDERFLOW;
                    else
                    begin
                        r.value = shadow_store[sel + STACK_COUNT*(cnt-1)];
                        if (kind == OP_POP)
                            cnt--;
                    end
                end
                default: ;
            endcase
            shadow_fill[sel] = cnt;
            r.empty = (cnt == 0);
        end
        return r;
    endfunction

    // drive one item, hold it until taken, then record its expected result
    task automatic send_item(op_t kind, logic [1:0] sel, logic signed [DATA_W-1:0] value);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start      <= 1'b1;
        op         <= kind;
        stack_sel  <= sel;
        push_value <= value;
        @(posedge clk iff !busy);
        pending_results.push_back(apply_stack_op(kind, sel, value));
        items_sent++;
    endtask

    // hold off until every outstanding result has come back
    task automatic drain_results();
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // result checker
    always @(posedge clk)
    begin
        stack_result_t exp_r;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result: read_value %0d status %0d stack_empty %0d",
                       read_value, status, stack_empty);
                err_cnt++;
            end
            else
            begin
                exp_r = pending_results.pop_front();
                case (exp_r.code)
                    ST_OVERFLOW:  n_overflow++;
                    ST_UNDERFLOW: n_underflow++;
                    default:      n_ok++;
                endcase
                if (read_value !== exp_r.value)
                begin
                    $error("read_value: expected %0d, got %0d", exp_r.value, read_value);
                    err_cnt++;
                end
                if (status !== exp_r.code)
                begin
                    $error("status: expected %0d, got %0d", exp_r.code, status);
                    err_cnt++;
                end
                if (stack_empty !== exp_r.empty)
                begin
                    $error("stack_empty: expected %0d, got %0d", exp_r.empty, stack_empty);
                    err_cnt++;
                end
            end
        end
    end

    // empty-stack errors, value extremes, every op and the unused select
    task automatic test_directed_basics();
        send_item(OP_QUERY, 2'd0, 32'sd0);
        send_item(OP_POP,   2'd1, 32'sd0);
        send_item(OP_PEEK,  2'd2, 32'sd0);
        send_item(OP_PUSH,  2'd0, 32'sh7fffffff);
        send_item(OP_PUSH,  2'd1, 32'sh80000000);
        send_item(OP_PUSH,  2'd2, -32'sd1);
        send_item(OP_PUSH,  2'd0, 32'sd0);
        send_item(OP_PUSH,  2'd1, 32'sh55555555);
        send_item(OP_PUSH,  2'd2, 32'shaaaaaaaa);
        send_item(OP_PEEK,  2'd0, 32'sd0);
        send_item(OP_POP,   2'd0, 32'sd0);
        send_item(OP_POP,   2'd0, 32'sd0);
        send_item(OP_QUERY, 2'd0, 32'sd0);
        send_item(OP_POP,   2'd1, 32'sd0);
        send_item(OP_PEEK,  2'd1, 32'sd0);
        send_item(OP_POP,   2'd2, 32'sd0);
        send_item(OP_QUERY, 2'd2, 32'sd0);
        send_item(OP_PUSH,  2'd3, -32'sd1);
        send_item(OP_POP,   2'd3, 32'sd0);
        send_item(OP_PEEK,  2'd3, 32'sd0);
        send_item(OP_QUERY, 2'd3, 32'sd0);
    endtask

    // fill one stack past capacity, then drain it past empty
    task automatic test_full_and_drain(logic [1:0] sel);
        for (int i = 0; i < DEPTH_PER_STACK + 2; i++)
            send_item(OP_PUSH, sel, $urandom());
        send_item(OP_PEEK, sel, $urandom());
        send_item(OP_QUERY, sel, $urandom());
        for (int i = 0; i < DEPTH_PER_STACK + 1; i++)
            send_item(OP_POP, sel, $urandom());
    endtask

    function automatic op_t pick_op(bit filling);
        int r;
        r = $urandom_range(99);
        if (r < (filling ? 70 : 15))
            return OP_PUSH;
        else if (r < 85)
            return OP_POP;
        else if (r < 93)
            return OP_PEEK;
        return OP_QUERY;
    endfunction

    // runs that drive one stack toward full or empty, mixed with the others
    task automatic test_random_traffic(int n_items, int sender_idle);
        int         run_left;
        bit         filling;
        logic [1:0] focus;
        logic [1:0] sel;
        idle_pct = sender_idle;
        run_left = 0;
        filling  = 1'b1;
        focus    = 2'd0;
        for (int i = 0; i < n_items; i++)
        begin
            if (run_left == 0)
            begin
                run_left = $urandom_range(120, 30);
                filling  = 1'($urandom_range(1));
                focus    = 2'($urandom_range(STACK_COUNT - 1));
            end
            run_left--;
            if ($urandom_range(99) < 4)
                sel = 2'd3;
            else if ($urandom_range(99) < 70)
                sel = focus;
            else
                sel = 2'($urandom_range(STACK_COUNT - 1));
            send_item(pick_op(filling), sel, $urandom());
        end
        drain_results();
    endtask

    initial
    begin
        rst_n      <= 1'b0;
        start      <= 1'b0;
        op         <= OP_PUSH;
        stack_sel  <= 2'd0;
        push_value <= '0;
        idle_pct    = 0;
        err_cnt     = 0;
        items_sent  = 0;
        n_ok        = 0;
        n_overflow  = 0;
        n_underflow = 0;
        for (int s = 0; s < STACK_COUNT; s++)
            shadow_fill[s] = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_basics();
        test_full_and_drain(2'd1);
        drain_results();
        test_random_traffic(290, 24);
        test_random_traffic(290, 64);
        test_random_traffic(290, 0);

        // wait out the outstanding results
        drain_results();
        repeat (8) @(posedge clk);
        $display("covered %0d items over push, pop, peek and query on all four selects,",
                 items_sent);
        $display("with %0d ok, %0d overflow and %0d underflow results checked",
                 n_ok, n_overflow, n_underflow);
        if (err_cnt == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

[three_stacks_interleaved_store.f]
rtl/tsis_pkg.sv
rtl/tsis_cell.sv
rtl/tsis_stack.sv
rtl/three_stacks_interleaved_store.sv
sim/tb_three_stacks_interleaved_store.sv
